>>> rtl/cfa_pkg.sv
// shared constants and types for the contiguous frame allocator
package cfa_pkg;

    localparam int NUM_FRAMES = 32;
    localparam int IDX_W      = $clog2(NUM_FRAMES);
    localparam int CNT_W      = 6;
    localparam int FRAME_W    = 5;
    localparam int STAT_W     = 2;
    localparam int SUM_W      = $clog2(NUM_FRAMES + 64) + 1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOSPACE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD     = 2'd2;

    typedef struct packed {
        logic             active;
        logic             found;
        logic [CNT_W-1:0] run;
        logic [IDX_W-1:0] end_idx;
    } wave_t;

    typedef struct packed {
        logic             set;
        logic             clr;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
    } mark_t;

endpackage

>>> rtl/cfa_req_if.sv
// request channel: command, page count and first frame
interface cfa_req_if;
    import cfa_pkg::*;

    logic               valid;
    logic               ready;
    logic               command;
    logic [CNT_W-1:0]   page_count;
    logic [FRAME_W-1:0] first_frame;

    modport source (output valid, command, page_count, first_frame, input ready);
    modport sink   (input valid, command, page_count, first_frame, output ready);

endinterface

>>> rtl/cfa_rsp_if.sv
// response channel: status and granted frame
interface cfa_rsp_if;
    import cfa_pkg::*;

    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [FRAME_W-1:0] granted_frame;

    modport source (output valid, status, granted_frame, input ready);
    modport sink   (input valid, status, granted_frame, output ready);

endinterface

>>> rtl/contiguous_frame_allocator.sv
// top level: first-fit contiguous frame allocator over a chain of frame cells
//
// Requests arrive on req (valid/ready): command 0 allocates page_count
// consecutive frames, command 1 frees page_count frames from first_frame.
// Each request gives one item on rsp: status (done, no space, bad request)
// and granted_frame (first frame of the run, 0 unless an allocate succeeds).
// An allocate sends a scan wave down the row of NUM_FRAMES cells, one cell
// per cycle; the wave counts free frames and records where the first long
// enough run ends, then the whole run is marked used at once.
// An allocate waits until the wave leaves the last cell, even when the run
// was found early; free and rejected requests go straight to the response.
// One request is in work at a time; the next request is taken the cycle
// after the response is loaded into the output register.
// The response sits in an output register: a new request is taken while an
// earlier response still waits, and a stalled receiver only holds the block
// once the next result is ready. Reset marks every frame free, with no
// clearing pass.
module contiguous_frame_allocator (
    input  logic     clk,
    input  logic     rst_n,
    cfa_req_if.sink  req,
    cfa_rsp_if.source rsp
);
    import cfa_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic               launch_reg;
    logic               launch_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [STAT_W-1:0]  res_stat_reg;
    logic [STAT_W-1:0]  res_stat_next;
    logic [FRAME_W-1:0] res_gnt_reg;
    logic [FRAME_W-1:0] res_gnt_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [STAT_W-1:0]  out_stat_reg;
    logic [STAT_W-1:0]  out_stat_next;
    logic [FRAME_W-1:0] out_gnt_reg;
    logic [FRAME_W-1:0] out_gnt_next;

    logic               accept;
    logic               load_out;
    logic [SUM_W-1:0]   free_end;
    logic               bad_free;
    logic [SUM_W-1:0]   start_sum;
    mark_t              mark;
    wave_t              wave_chain [NUM_FRAMES+1];
    wave_t              tail;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    assign wave_chain[0] = '{active: launch_reg, found: 1'b0, run: '0, end_idx: '0};
    assign tail          = wave_chain[NUM_FRAMES];

    genvar gi;
    generate
        for (gi = 0; gi < NUM_FRAMES; gi++)
        begin : g_cell
            cfa_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cell_idx   (IDX_W'(gi)),
                .page_count (cnt_reg),
                .mark       (mark),
                .wave_in    (wave_chain[gi]),
                .wave_out   (wave_chain[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        free_end  = SUM_W'(req.first_frame) + SUM_W'(req.page_count);
        bad_free  = (req.page_count == '0) || (free_end > SUM_W'(NUM_FRAMES));
        start_sum = SUM_W'(tail.end_idx) + SUM_W'(1) - SUM_W'(cnt_reg);
    end

    always_comb
    begin
        mark = '0;
        if (accept && (req.command == CMD_FREE) && !bad_free)
        begin
            mark.clr = 1'b1;
            mark.lo  = IDX_W'(req.first_frame);
            mark.hi  = IDX_W'(free_end - SUM_W'(1));
        end
        else if ((state_reg == S_SCAN) && tail.active && tail.found)
        begin
            mark.set = 1'b1;
            mark.lo  = IDX_W'(start_sum);
            mark.hi  = tail.end_idx;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        launch_next   = 1'b0;
        cnt_next      = cnt_reg;
        res_stat_next = res_stat_reg;
        res_gnt_next  = res_gnt_reg;
        load_out      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cnt_next     = req.page_count;
                    res_gnt_next = '0;
                    if (req.command == CMD_ALLOC)
                    begin
                        if (req.page_count == '0)
                        begin
                            res_stat_next = STAT_BAD;
                            state_next    = S_DONE;
                        end
                        else
                        begin
                            launch_next = 1'b1;
                            state_next  = S_SCAN;
                        end
                    end
                    else
                    begin
                        res_stat_next = bad_free ? STAT_BAD : STAT_DONE;
                        state_next    = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                if (tail.active)
                begin
                    res_stat_next = tail.found ? STAT_DONE : STAT_NOSPACE;
                    res_gnt_next  = tail.found ? FRAME_W'(start_sum) : '0;
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_stat_next  = out_stat_reg;
        out_gnt_next   = out_gnt_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_stat_next  = res_stat_reg;
            out_gnt_next   = res_gnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        res_stat_reg <= res_stat_next;
        res_gnt_reg  <= res_gnt_next;
        out_stat_reg <= out_stat_next;
        out_gnt_reg  <= out_gnt_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_stat_reg;
    assign rsp.granted_frame = out_gnt_reg;

`ifndef SYNTHESIS
    a_idle_no_wave: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!launch_reg && !tail.active))
        else $error("scan wave alive while idle");

    a_wave_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tail.active |-> (state_reg == S_SCAN))
        else $error("scan wave finished outside scan");

    a_mark_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mark.set && mark.clr))
        else $error("set and clear marks together");

    a_mark_order: assert property (@(posedge clk) disable iff (!rst_n)
        (mark.set || mark.clr) |-> (mark.lo <= mark.hi))
        else $error("mark range reversed");

    a_gnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != STAT_DONE)) |-> (rsp.granted_frame == '0))
        else $error("granted frame nonzero on failed request");
`endif

endmodule

>>> rtl/cfa_cell.sv
// one frame cell: in-use bit plus one stage of the free-run scan wave
module cfa_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [cfa_pkg::IDX_W-1:0] cell_idx,
    input  logic [cfa_pkg::CNT_W-1:0] page_count,
    input  cfa_pkg::mark_t            mark,
    input  cfa_pkg::wave_t            wave_in,
    output cfa_pkg::wave_t            wave_out
);
    import cfa_pkg::*;

    logic             used_reg;
    logic             used_next;
    wave_t            wave_reg;
    wave_t            wave_next;
    logic [CNT_W-1:0] run_inc;
    logic             hit;
    logic             in_range;

    always_comb
    begin
        run_inc   = wave_in.run + CNT_W'(1);
        hit       = wave_in.active && !wave_in.found && !used_reg && (run_inc == page_count);
        wave_next = wave_in;
        if (wave_in.active && !wave_in.found)
        begin
            wave_next.run = used_reg ? '0 : run_inc;
            if (hit)
            begin
                wave_next.found   = 1'b1;
                wave_next.end_idx = cell_idx;
            end
        end
    end

    always_comb
    begin
        in_range  = (cell_idx >= mark.lo) && (cell_idx <= mark.hi);
        used_next = used_reg;
        if (mark.set && in_range)
        begin
            used_next = 1'b1;
        end
        else if (mark.clr && in_range)
        begin
            used_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            wave_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
            wave_reg <= wave_next;
        end
    end

    assign wave_out = wave_reg;

endmodule

>>> tb/sv/contiguous_frame_allocator_tb.sv
// self-checking testbench for the contiguous frame allocator
module contiguous_frame_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cfa_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 950;
    localparam int TAIL_CYCLES  = NUM_FRAMES + 8;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [FRAME_W-1:0] granted_frame;
    } allocator_reply_t;

    typedef struct {
        int run_first;
        int run_len;
    } frame_run_t;

    logic clk;
    logic rst_n;

    cfa_req_if req_ch ();
    cfa_rsp_if rsp_ch ();

    contiguous_frame_allocator i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    bit               frame_used [NUM_FRAMES];
    allocator_reply_t expected_replies [$];
    frame_run_t       live_runs [$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  stall_pct      = 0;
    int  hold_request   = 0;
    int  hold_left      = 0;
    int  burst_left     = 0;
    bit  sender_pacing  = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[contiguous_frame_allocator] ERROR");
        $finish;
    end

    // first-fit allocation and frees over the frame map, applied at acceptance
    function automatic allocator_reply_t predict_reply(input logic cmd,
                                                       input logic [CNT_W-1:0] cnt,
                                                       input logic [FRAME_W-1:0] first);
        allocator_reply_t reply;
        int               run;
        int               run_start;
        int               len;
        int               i;
        reply.status        = STAT_DONE;
        reply.granted_frame = '0;
        len                 = int'(cnt);
        if (cmd == CMD_ALLOC)
        begin
            if (len == 0)
            begin
                reply.status = STAT_BAD;
            end
            else
            begin
                run       = 0;
                run_start = 0;
                for (i = 0; i < NUM_FRAMES && run < len; i++)
                begin
                    if (!frame_used[i])
                    begin
                        if (run == 0)
                            run_start = i;
                        run++;
                    end
                    else
                    begin
                        run = 0;
                    end
                end
                if (run < len)
                begin
                    reply.status = STAT_NOSPACE;
                end
                else
                begin
                    for (i = run_start; i < run_start + len; i++)
                        frame_used[i] = 1'b1;
                    reply.granted_frame = run_start[FRAME_W-1:0];
                end
            end
        end
        else
        begin
            if (len == 0 || int'(first) + len > NUM_FRAMES)
                reply.status = STAT_BAD;
            else
                for (i = int'(first); i < int'(first) + len; i++)
                    frame_used[i] = 1'b0;
        end
        return reply;
    endfunction

    task automatic send_request(input logic cmd, input int cnt, input int first);
        allocator_reply_t reply;
        frame_run_t       granted_run;
        if (sender_pacing)
        begin
            if (burst_left == 0)
            begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge clk);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        req_ch.valid       <= 1'b1;
        req_ch.command     <= cmd;
        req_ch.page_count  <= cnt[CNT_W-1:0];
        req_ch.first_frame <= first[FRAME_W-1:0];
        do
            @(posedge clk);
        while (!req_ch.ready);
        reply = predict_reply(cmd, cnt[CNT_W-1:0], first[FRAME_W-1:0]);
        expected_replies.push_back(reply);
        if (cmd == CMD_ALLOC && reply.status == STAT_DONE)
        begin
            granted_run.run_first = int'(reply.granted_frame);
            granted_run.run_len   = cnt;
            live_runs.push_back(granted_run);
        end
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_reply();
        allocator_reply_t want;
        if (expected_replies.size() == 0)
        begin
            $error("unexpected reply: status %0d granted_frame %0d",
                   rsp_ch.status, rsp_ch.granted_frame);
            mismatch_count++;
        end
        else
        begin
            want = expected_replies.pop_front();
            if (rsp_ch.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                mismatch_count++;
            end
            if (rsp_ch.granted_frame !== want.granted_frame)
            begin
                $error("granted_frame: expected %0d, actual %0d",
                       want.granted_frame, rsp_ch.granted_frame);
                mismatch_count++;
            end
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                check_reply();
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (!rst_n)
            begin
                rsp_ch.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic test_alloc_limits();
        send_request(CMD_ALLOC, 1, $urandom_range(31));
        send_request(CMD_ALLOC, 0, $urandom_range(31));
        send_request(CMD_ALLOC, 63, $urandom_range(31));
        send_request(CMD_ALLOC, NUM_FRAMES + 1, $urandom_range(31));
        send_request(CMD_ALLOC, NUM_FRAMES - 1, $urandom_range(31));
        send_request(CMD_ALLOC, 1, $urandom_range(31));
    endtask

    task automatic test_free_limits();
        send_request(CMD_FREE, 0, 5);
        send_request(CMD_FREE, 2, 31);
        send_request(CMD_FREE, 63, 31);
        send_request(CMD_FREE, 1, 31);
        send_request(CMD_FREE, 1, 31);
        send_request(CMD_FREE, NUM_FRAMES, 0);
        send_request(CMD_ALLOC, NUM_FRAMES, $urandom_range(31));
        send_request(CMD_FREE, NUM_FRAMES, 0);
    endtask

    task automatic test_first_fit();
        send_request(CMD_ALLOC, 4, 0);
        send_request(CMD_ALLOC, 4, 31);
        send_request(CMD_ALLOC, 4, 16);
        send_request(CMD_FREE, 4, 4);
        send_request(CMD_ALLOC, 5, 3);
        send_request(CMD_ALLOC, 3, 21);
        send_request(CMD_ALLOC, 1, 10);
        send_request(CMD_FREE, NUM_FRAMES, 0);
        live_runs.delete();
    endtask

    // long receiver hold so the output register fills and input stalls
    task automatic test_output_backpressure();
        int n;
        sender_pacing = 1'b0;
        stall_pct     = 0;
        hold_request  = 300;
        for (n = 0; n < 16; n++)
        begin
            if (n % 3 == 0)
                send_request(CMD_ALLOC, $urandom_range(1, 4), $urandom_range(31));
            else
                send_request(CMD_FREE, $urandom_range(0, 6), $urandom_range(31));
        end
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int         n;
        int         pick;
        int         idx;
        int         cnt;
        frame_run_t victim;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 120 == 0)
            begin
                case ((n / 120) % 4)
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 55;
                    default: stall_pct = 85;
                endcase
                sender_pacing = ((n / 120) % 3 != 1);
            end
            if (n == RANDOM_ITEMS / 2)
                wait_drained();
            pick = $urandom_range(99);
            if (pick < 45 || (pick < 85 && live_runs.size() == 0))
            begin
                pick = $urandom_range(99);
                if (pick < 80)
                    cnt = $urandom_range(1, 8);
                else if (pick < 93)
                    cnt = $urandom_range(9, NUM_FRAMES);
                else if (pick < 96)
                    cnt = 0;
                else
                    cnt = $urandom_range(NUM_FRAMES + 1, 63);
                send_request(CMD_ALLOC, cnt, $urandom_range(31));
            end
            else if (pick < 85)
            begin
                idx    = $urandom_range(live_runs.size() - 1);
                victim = live_runs[idx];
                live_runs.delete(idx);
                send_request(CMD_FREE, victim.run_len, victim.run_first);
            end
            else if (pick < 97)
            begin
                send_request(CMD_FREE, $urandom_range(0, 63), $urandom_range(31));
            end
            else
            begin
                send_request(CMD_FREE, NUM_FRAMES, 0);
                live_runs.delete();
            end
        end
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.command     <= CMD_ALLOC;
        req_ch.page_count  <= '0;
        req_ch.first_frame <= '0;
        rsp_ch.ready       <= 1'b0;
        frame_used = '{default: 1'b0};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_alloc_limits();
        test_free_limits();
        test_first_fit();
        wait_drained();
        test_output_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_replies.size() == 0)
            $display("[contiguous_frame_allocator] OK");
        else
            $display("[contiguous_frame_allocator] ERROR");
        $finish;
    end

endmodule
